>>> sv/ecsm_pkg.sv
// ----------------------------------------------------------------------------
// ecsm_pkg
// Shared widths, types, register indexes and modular add/subtract helpers
// for the elliptic-curve scalar multiplier.
// ----------------------------------------------------------------------------
package ecsm_pkg;

  localparam int COORD_WIDTH  = 64;
  localparam int SCALAR_WIDTH = 64;
  localparam int IDX_W        = $clog2(SCALAR_WIDTH);
  localparam int CNT_W        = $clog2(COORD_WIDTH);
  localparam int CFG_IDX_W    = 4;

  typedef logic [COORD_WIDTH-1:0]  coord_t;
  typedef logic [SCALAR_WIDTH-1:0] scalar_t;

  localparam coord_t PRIME_RESET = COORD_WIDTH'(64'hFFFF_FFFF_FFFF_FFC5);
  localparam coord_t CURVE_A_RESET = COORD_WIDTH'(64'hFFFF_FFFF_FFFF_FFC2);
  localparam coord_t MIN_PRIME = COORD_WIDTH'(3);

  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_MODULUS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A       = CFG_IDX_W'(1);

  typedef struct packed {
    logic   inf;
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   inf;
    logic   err;
  } result_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_X,
    ST_RED_Y,
    ST_DBL_CHK,
    ST_PA_CASE,
    ST_PA_X2,
    ST_PA_N1,
    ST_PA_N2,
    ST_PA_N3,
    ST_INV_INIT,
    ST_INV_CHK,
    ST_INV_DIV,
    ST_INV_MUL,
    ST_INV_UPD,
    ST_PA_L,
    ST_PA_L2,
    ST_PA_SX1,
    ST_PA_SX2,
    ST_PA_D,
    ST_PA_E,
    ST_PA_SY,
    ST_PA_END,
    ST_ACC_CHK,
    ST_ACC_BIT,
    ST_ACC_LD,
    ST_DONE
  } ecsm_state_t;

  // Operands are below m, so one conditional subtract brings the sum back.
  function automatic coord_t fadd(coord_t a, coord_t b, coord_t m);
    logic [COORD_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[COORD_WIDTH-1:0];
  endfunction

  function automatic coord_t fsub(coord_t a, coord_t b, coord_t m);
    return (a >= b) ? (a - b) : (a - b + m);
  endfunction

endpackage

>>> sv/ecsm_if.sv
// ----------------------------------------------------------------------------
// ecsm_if
// Valid/ready channels carrying the base point and scalar in, and the
// resulting point out.
// ----------------------------------------------------------------------------
interface ecsm_in_if;
  logic                 valid;
  logic                 ready;
  ecsm_pkg::coord_t     point_x;
  ecsm_pkg::coord_t     point_y;
  logic                 point_is_infinity;
  ecsm_pkg::scalar_t    scalar;

  modport source (output valid, point_x, point_y, point_is_infinity, scalar,
                  input ready);
  modport sink (input valid, point_x, point_y, point_is_infinity, scalar,
                output ready);
endinterface

interface ecsm_out_if;
  logic                 valid;
  logic                 ready;
  ecsm_pkg::coord_t     result_x;
  ecsm_pkg::coord_t     result_y;
  logic                 result_is_infinity;
  logic                 zero_scalar_error;

  modport source (output valid, result_x, result_y, result_is_infinity,
                  zero_scalar_error, input ready);
  modport sink (input valid, result_x, result_y, result_is_infinity,
                zero_scalar_error, output ready);
endinterface

>>> sv/ecsm_fmul.sv
// ----------------------------------------------------------------------------
// ecsm_fmul
// Bit-serial modular multiplier: scans the multiplier from its top bit,
// doubling and conditionally adding, one modular add per cycle.
// ----------------------------------------------------------------------------
module ecsm_fmul (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  ecsm_pkg::coord_t op_a,
  input  ecsm_pkg::coord_t op_b,
  input  ecsm_pkg::coord_t modulus,
  output logic             done,
  output ecsm_pkg::coord_t prod
);

  localparam logic [ecsm_pkg::CNT_W-1:0] LAST_BIT =
    ecsm_pkg::CNT_W'(ecsm_pkg::COORD_WIDTH - 1);

  logic                        busy_r;
  logic                        done_r;
  logic                        add_ph_r;
  logic [ecsm_pkg::CNT_W-1:0]  cnt_r;
  ecsm_pkg::coord_t            acc_r;
  ecsm_pkg::coord_t            a_r;
  ecsm_pkg::coord_t            b_r;
  ecsm_pkg::coord_t            m_r;
  ecsm_pkg::coord_t            sum;

  assign sum  = ecsm_pkg::fadd(acc_r, add_ph_r ? a_r : acc_r, m_r);
  assign done = done_r;
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r   <= 1'b1;
        add_ph_r <= 1'b0;
        cnt_r    <= '0;
        acc_r    <= '0;
        a_r      <= op_a;
        b_r      <= op_b;
        m_r      <= modulus;
      end else if (busy_r) begin
        if (!add_ph_r) begin
          acc_r    <= sum;
          add_ph_r <= 1'b1;
        end else begin
          if (b_r[ecsm_pkg::COORD_WIDTH-1]) begin
            acc_r <= sum;
          end
          b_r      <= {b_r[ecsm_pkg::COORD_WIDTH-2:0], 1'b0};
          add_ph_r <= 1'b0;
          cnt_r    <= cnt_r + ecsm_pkg::CNT_W'(1);
          if (cnt_r == LAST_BIT) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

endmodule

>>> sv/ecsm_fdiv.sv
// ----------------------------------------------------------------------------
// ecsm_fdiv
// Restoring radix-2 divider giving quotient and remainder, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module ecsm_fdiv (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  ecsm_pkg::coord_t dividend,
  input  ecsm_pkg::coord_t divisor,
  output logic             done,
  output ecsm_pkg::coord_t quot,
  output ecsm_pkg::coord_t rem
);

  localparam logic [ecsm_pkg::CNT_W-1:0] LAST_BIT =
    ecsm_pkg::CNT_W'(ecsm_pkg::COORD_WIDTH - 1);

  logic                            busy_r;
  logic                            done_r;
  logic [ecsm_pkg::CNT_W-1:0]      cnt_r;
  ecsm_pkg::coord_t                rem_r;
  ecsm_pkg::coord_t                quo_r;
  ecsm_pkg::coord_t                dvs_r;
  logic [ecsm_pkg::COORD_WIDTH:0]  trial;
  logic [ecsm_pkg::COORD_WIDTH:0]  diff;
  logic                            ge;

  assign trial = {rem_r, quo_r[ecsm_pkg::COORD_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});
  assign done  = done_r;
  assign quot  = quo_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? diff[ecsm_pkg::COORD_WIDTH-1:0] : trial[ecsm_pkg::COORD_WIDTH-1:0];
        quo_r <= {quo_r[ecsm_pkg::COORD_WIDTH-2:0], ge};
        cnt_r <= cnt_r + ecsm_pkg::CNT_W'(1);
        if (cnt_r == LAST_BIT) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/ecsm_core.sv
// ----------------------------------------------------------------------------
// ecsm_core
// Sequencer for double-and-add: reduces the operands, builds the table of
// doublings in a memory, then folds the set scalar bits from the top down.
// Point addition and Euclidean inversion run on the shared serial units.
// ----------------------------------------------------------------------------
module ecsm_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ecsm_pkg::point_t  in_pt,
  input  ecsm_pkg::scalar_t in_scalar,
  input  ecsm_pkg::coord_t  prime,
  input  ecsm_pkg::coord_t  curve_a,
  output logic              ready,
  output logic              res_valid,
  input  logic              res_ready,
  output ecsm_pkg::result_t res
);

  ecsm_pkg::ecsm_state_t state_r, state_nxt;
  logic                  go_r, go_nxt;
  logic                  dbl_r, dbl_nxt;
  logic [ecsm_pkg::IDX_W-1:0] idx_r, idx_nxt;
  ecsm_pkg::scalar_t     k_r, k_nxt;
  ecsm_pkg::scalar_t     kd_r, kd_nxt;
  ecsm_pkg::coord_t      m_r, m_nxt;
  ecsm_pkg::coord_t      a_r, a_nxt;
  ecsm_pkg::point_t      p_r, p_nxt;
  ecsm_pkg::point_t      q_r, q_nxt;
  ecsm_pkg::point_t      s_r, s_nxt;
  ecsm_pkg::coord_t      num_r, num_nxt;
  ecsm_pkg::coord_t      den_r, den_nxt;
  ecsm_pkg::coord_t      t_r, t_nxt;
  ecsm_pkg::coord_t      l_r, l_nxt;
  ecsm_pkg::coord_t      r0_r, r0_nxt;
  ecsm_pkg::coord_t      r1_r, r1_nxt;
  ecsm_pkg::coord_t      t0_r, t0_nxt;
  ecsm_pkg::coord_t      t1_r, t1_nxt;
  ecsm_pkg::coord_t      qt_r, qt_nxt;
  ecsm_pkg::coord_t      rr_r, rr_nxt;
  ecsm_pkg::result_t     res_r, res_nxt;

  ecsm_pkg::point_t      pw_mem [ecsm_pkg::SCALAR_WIDTH];
  ecsm_pkg::point_t      rd_data_r;
  logic                  mem_we;
  logic [ecsm_pkg::IDX_W-1:0] mem_wa;
  ecsm_pkg::point_t      mem_wd;

  logic                  mul_start, mul_done;
  ecsm_pkg::coord_t      mul_a, mul_b, mul_prod;
  logic                  div_start, div_done;
  ecsm_pkg::coord_t      div_n, div_d, div_quot, div_rem;

  ecsm_pkg::coord_t      two_y;

  assign two_y = ecsm_pkg::fadd(p_r.y, p_r.y, m_r);

  ecsm_fmul u_fmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .modulus (m_r),
    .done    (mul_done),
    .prod    (mul_prod)
  );

  ecsm_fdiv u_fdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ecsm_pkg::ST_IDLE;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dbl_r <= dbl_nxt;
    idx_r <= idx_nxt;
    k_r   <= k_nxt;
    kd_r  <= kd_nxt;
    m_r   <= m_nxt;
    a_r   <= a_nxt;
    p_r   <= p_nxt;
    q_r   <= q_nxt;
    s_r   <= s_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    t_r   <= t_nxt;
    l_r   <= l_nxt;
    r0_r  <= r0_nxt;
    r1_r  <= r1_nxt;
    t0_r  <= t0_nxt;
    t1_r  <= t1_nxt;
    qt_r  <= qt_nxt;
    rr_r  <= rr_nxt;
    res_r <= res_nxt;
  end

  // Table of doublings: entry i holds 2^i times the base point.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pw_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= pw_mem[idx_r];
  end

  always_comb begin
    state_nxt = state_r;
    go_nxt    = go_r;
    dbl_nxt   = dbl_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    kd_nxt    = kd_r;
    m_nxt     = m_r;
    a_nxt     = a_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    s_nxt     = s_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    t_nxt     = t_r;
    l_nxt     = l_r;
    r0_nxt    = r0_r;
    r1_nxt    = r1_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    qt_nxt    = qt_r;
    rr_nxt    = rr_r;
    res_nxt   = res_r;
    ready     = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = idx_r;
    mem_wd    = s_r;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = m_r;

    case (state_r)
      ecsm_pkg::ST_IDLE: begin
        ready = 1'b1;
        if (start) begin
          p_nxt   = in_pt;
          k_nxt   = in_scalar;
          kd_nxt  = in_scalar;
          idx_nxt = '0;
          a_nxt   = curve_a;
          m_nxt   = (prime < ecsm_pkg::MIN_PRIME) ? ecsm_pkg::MIN_PRIME : prime;
          if (in_scalar == '0) begin
            res_nxt   = '{x: '0, y: '0, inf: 1'b1, err: 1'b1};
            state_nxt = ecsm_pkg::ST_DONE;
          end else begin
            state_nxt = ecsm_pkg::ST_RED_A;
          end
        end
      end

      ecsm_pkg::ST_RED_A: begin
        div_n = a_r;
        if (!go_r) begin
          div_start = 1'b1;
          go_nxt    = 1'b1;
        end else if (div_done) begin
          go_nxt    = 1'b0;
          a_nxt     = div_rem;
          state_nxt = ecsm_pkg::ST_RED_X;
        end
      end

      ecsm_pkg::ST_RED_X: begin
        div_n = p_r.x;
        if (!go_r) begin
          div_start = 1'b1;
          go_nxt    = 1'b1;
        end else if (div_done) begin
          go_nxt    = 1'b0;
          p_nxt.x   = div_rem;
          state_nxt = ecsm_pkg::ST_RED_Y;
        end
      end

      ecsm_pkg::ST_RED_Y: begin
        div_n = p_r.y;
        if (!go_r) begin
          div_start = 1'b1;
          go_nxt    = 1'b1;
        end else if (div_done) begin
          go_nxt    = 1'b0;
          p_nxt.y   = div_rem;
          mem_we    = 1'b1;
          mem_wa    = '0;
          mem_wd    = '{inf: p_r.inf, x: p_r.x, y: div_rem};
          state_nxt = ecsm_pkg::ST_DBL_CHK;
        end
      end

      ecsm_pkg::ST_DBL_CHK: begin
        q_nxt = p_r;
        if (kd_r[ecsm_pkg::SCALAR_WIDTH-1:1] != '0) begin
          dbl_nxt   = 1'b1;
          state_nxt = ecsm_pkg::ST_PA_CASE;
        end else begin
          // The current point is the top power; it seeds the accumulator.
          dbl_nxt   = 1'b0;
          state_nxt = ecsm_pkg::ST_ACC_CHK;
        end
      end

      ecsm_pkg::ST_PA_CASE: begin
        if (p_r.inf && q_r.inf) begin
          s_nxt     = '{inf: 1'b1, x: '0, y: '0};
          state_nxt = ecsm_pkg::ST_PA_END;
        end else if (q_r.inf) begin
          s_nxt     = p_r;
          state_nxt = ecsm_pkg::ST_PA_END;
        end else if (p_r.inf) begin
          s_nxt     = q_r;
          state_nxt = ecsm_pkg::ST_PA_END;
        end else if (p_r.x != q_r.x) begin
          num_nxt   = ecsm_pkg::fsub(q_r.y, p_r.y, m_r);
          den_nxt   = ecsm_pkg::fsub(q_r.x, p_r.x, m_r);
          state_nxt = ecsm_pkg::ST_INV_INIT;
        end else if ((p_r.y == q_r.y) && (two_y != '0)) begin
          den_nxt   = two_y;
          state_nxt = ecsm_pkg::ST_PA_X2;
        end else begin
          s_nxt     = '{inf: 1'b1, x: '0, y: '0};
          state_nxt = ecsm_pkg::ST_PA_END;
        end
      end

      ecsm_pkg::ST_PA_X2: begin
        mul_a = p_r.x;
        mul_b = p_r.x;
        if (!go_r) begin
          mul_start = 1'b1;
          go_nxt    = 1'b1;
        end else if (mul_done) begin
          go_nxt    = 1'b0;
          t_nxt     = mul_prod;
          state_nxt = ecsm_pkg::ST_PA_N1;
        end
      end

      ecsm_pkg::ST_PA_N1: begin
        num_nxt   = ecsm_pkg::fadd(t_r, t_r, m_r);
        state_nxt = ecsm_pkg::ST_PA_N2;
      end

      ecsm_pkg::ST_PA_N2: begin
        num_nxt   = ecsm_pkg::fadd(num_r, t_r, m_r);
        state_nxt = ecsm_pkg::ST_PA_N3;
      end

      ecsm_pkg::ST_PA_N3: begin
        num_nxt   = ecsm_pkg::fadd(num_r, a_r, m_r);
        state_nxt = ecsm_pkg::ST_INV_INIT;
      end

      ecsm_pkg::ST_INV_INIT: begin
        r0_nxt    = m_r;
        r1_nxt    = den_r;
        t0_nxt    = '0;
        t1_nxt    = ecsm_pkg::COORD_WIDTH'(1);
        state_nxt = ecsm_pkg::ST_INV_CHK;
      end

      ecsm_pkg::ST_INV_CHK: begin
        if (r1_r == '0) begin
          state_nxt = ecsm_pkg::ST_PA_L;
        end else begin
          state_nxt = ecsm_pkg::ST_INV_DIV;
        end
      end

      ecsm_pkg::ST_INV_DIV: begin
        div_n = r0_r;
        div_d = r1_r;
        if (!go_r) begin
          div_start = 1'b1;
          go_nxt    = 1'b1;
        end else if (div_done) begin
          go_nxt    = 1'b0;
          qt_nxt    = div_quot;
          rr_nxt    = div_rem;
          state_nxt = ecsm_pkg::ST_INV_MUL;
        end
      end

      // t1 is below m, so t1 * q mod m equals (q mod m) * t1 mod m.
      ecsm_pkg::ST_INV_MUL: begin
        mul_a = t1_r;
        mul_b = qt_r;
        if (!go_r) begin
          mul_start = 1'b1;
          go_nxt    = 1'b1;
        end else if (mul_done) begin
          go_nxt    = 1'b0;
          t_nxt     = mul_prod;
          state_nxt = ecsm_pkg::ST_INV_UPD;
        end
      end

      ecsm_pkg::ST_INV_UPD: begin
        t1_nxt    = ecsm_pkg::fsub(t0_r, t_r, m_r);
        t0_nxt    = t1_r;
        r0_nxt    = r1_r;
        r1_nxt    = rr_r;
        state_nxt = ecsm_pkg::ST_INV_CHK;
      end

      ecsm_pkg::ST_PA_L: begin
        mul_a = num_r;
        mul_b = t0_r;
        if (!go_r) begin
          mul_start = 1'b1;
          go_nxt    = 1'b1;
        end else if (mul_done) begin
          go_nxt    = 1'b0;
          l_nxt     = mul_prod;
          state_nxt = ecsm_pkg::ST_PA_L2;
        end
      end

      ecsm_pkg::ST_PA_L2: begin
        mul_a = l_r;
        mul_b = l_r;
        if (!go_r) begin
          mul_start = 1'b1;
          go_nxt    = 1'b1;
        end else if (mul_done) begin
          go_nxt    = 1'b0;
          t_nxt     = mul_prod;
          state_nxt = ecsm_pkg::ST_PA_SX1;
        end
      end

      ecsm_pkg::ST_PA_SX1: begin
        s_nxt.x   = ecsm_pkg::fsub(t_r, p_r.x, m_r);
        state_nxt = ecsm_pkg::ST_PA_SX2;
      end

      ecsm_pkg::ST_PA_SX2: begin
        s_nxt.x   = ecsm_pkg::fsub(s_r.x, q_r.x, m_r);
        state_nxt = ecsm_pkg::ST_PA_D;
      end

      ecsm_pkg::ST_PA_D: begin
        t_nxt     = ecsm_pkg::fsub(p_r.x, s_r.x, m_r);
        state_nxt = ecsm_pkg::ST_PA_E;
      end

      ecsm_pkg::ST_PA_E: begin
        mul_a = l_r;
        mul_b = t_r;
        if (!go_r) begin
          mul_start = 1'b1;
          go_nxt    = 1'b1;
        end else if (mul_done) begin
          go_nxt    = 1'b0;
          t_nxt     = mul_prod;
          state_nxt = ecsm_pkg::ST_PA_SY;
        end
      end

      ecsm_pkg::ST_PA_SY: begin
        s_nxt.y   = ecsm_pkg::fsub(t_r, p_r.y, m_r);
        s_nxt.inf = 1'b0;
        state_nxt = ecsm_pkg::ST_PA_END;
      end

      ecsm_pkg::ST_PA_END: begin
        if (dbl_r) begin
          p_nxt     = s_r;
          mem_we    = 1'b1;
          mem_wa    = idx_r + ecsm_pkg::IDX_W'(1);
          idx_nxt   = idx_r + ecsm_pkg::IDX_W'(1);
          kd_nxt    = kd_r >> 1;
          state_nxt = ecsm_pkg::ST_DBL_CHK;
        end else begin
          q_nxt     = s_r;
          state_nxt = ecsm_pkg::ST_ACC_CHK;
        end
      end

      ecsm_pkg::ST_ACC_CHK: begin
        if (idx_r == '0) begin
          res_nxt.x   = q_r.inf ? '0 : q_r.x;
          res_nxt.y   = q_r.inf ? '0 : q_r.y;
          res_nxt.inf = q_r.inf;
          res_nxt.err = 1'b0;
          state_nxt   = ecsm_pkg::ST_DONE;
        end else begin
          idx_nxt   = idx_r - ecsm_pkg::IDX_W'(1);
          state_nxt = ecsm_pkg::ST_ACC_BIT;
        end
      end

      // The table read for this index is issued in this cycle.
      ecsm_pkg::ST_ACC_BIT: begin
        if (k_r[idx_r]) begin
          state_nxt = ecsm_pkg::ST_ACC_LD;
        end else begin
          state_nxt = ecsm_pkg::ST_ACC_CHK;
        end
      end

      ecsm_pkg::ST_ACC_LD: begin
        p_nxt     = rd_data_r;
        state_nxt = ecsm_pkg::ST_PA_CASE;
      end

      ecsm_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ecsm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ecsm_pkg::ST_IDLE;
        go_nxt    = 1'b0;
      end
    endcase
  end

  assign res = res_r;

  a_one_unit_start: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_start && div_start))
    else $error("multiplier and divider started together");

  a_error_is_infinity: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ecsm_pkg::ST_DONE && res_r.err) |-> res_r.inf)
    else $error("zero scalar result not at infinity");

  a_table_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == ecsm_pkg::ST_PA_END) |-> (idx_r != {ecsm_pkg::IDX_W{1'b1}}))
    else $error("doubling table index wrapped");

  a_modulus_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ecsm_pkg::ST_IDLE) |-> (m_r >= ecsm_pkg::MIN_PRIME))
    else $error("working modulus below three");

endmodule

>>> sv/ec_scalar_multiply_top.sv
// ----------------------------------------------------------------------------
// ec_scalar_multiply_top
// Affine elliptic-curve scalar multiplier over a prime field with a
// configurable modulus and curve coefficient a.
//
//   channel  | direction | handshake        | contents
//   in_ch    | in        | valid/ready      | point_x, point_y, point_is_infinity, scalar
//   out_ch   | out       | valid/ready      | result_x, result_y, result_is_infinity,
//            |           |                  | zero_scalar_error
//   cfg_*    | in        | write enable     | 0: prime_modulus, 1: curve_a
//
// One word is processed at a time. A zero scalar skips the point work;
// otherwise three reductions are followed by one point operation per
// doubling and per further set scalar bit (up to 2*W-2 for W = 64). Each
// operation is bounded by its inversion: up to about 1.44*W Euclid steps
// of one division plus one multiplication, plus up to four multiplications.
// Reset is synchronous; it clears control state and loads the configuration
// registers with their reset values. A stalled output holds its word; the
// next input word is taken while it waits.
// ----------------------------------------------------------------------------
module ec_scalar_multiply_top (
  input  logic                               clk,
  input  logic                               rst_n,
  ecsm_in_if.sink                            in_ch,
  ecsm_out_if.source                         out_ch,
  input  logic                               cfg_wr_en,
  input  logic [ecsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  ecsm_pkg::coord_t                   cfg_wdata
);

  ecsm_pkg::coord_t  prime_r;
  ecsm_pkg::coord_t  curve_a_r;
  logic              out_valid_r;
  ecsm_pkg::result_t out_res_r;

  logic              core_ready;
  logic              core_start;
  logic              res_valid;
  logic              res_ready;
  ecsm_pkg::result_t res;
  ecsm_pkg::point_t  in_pt;

  assign in_pt      = '{inf: in_ch.point_is_infinity, x: in_ch.point_x, y: in_ch.point_y};
  assign in_ch.ready = core_ready;
  assign core_start = in_ch.valid && core_ready;
  assign res_ready  = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r   <= ecsm_pkg::PRIME_RESET;
      curve_a_r <= ecsm_pkg::CURVE_A_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == ecsm_pkg::CFG_PRIME_MODULUS) begin
        prime_r <= cfg_wdata;
      end
      if (cfg_index == ecsm_pkg::CFG_CURVE_A) begin
        curve_a_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.result_x           = out_res_r.x;
  assign out_ch.result_y           = out_res_r.y;
  assign out_ch.result_is_infinity = out_res_r.inf;
  assign out_ch.zero_scalar_error  = out_res_r.err;

  ecsm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (core_start),
    .in_pt     (in_pt),
    .in_scalar (in_ch.scalar),
    .prime     (prime_r),
    .curve_a   (curve_a_r),
    .ready     (core_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

>>> sim/ec_scalar_multiply_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ec_scalar_multiply_top_tb
// Sends base points and scalars to the multiplier under several curve
// settings and compares every result word with a point multiple worked out
// here by affine double-and-add, while both channels idle and stall.
// ----------------------------------------------------------------------------
module ec_scalar_multiply_top_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [ecsm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  ecsm_pkg::coord_t cfg_wdata = '0;

  ecsm_in_if in_ch ();
  ecsm_out_if out_ch ();

  ec_scalar_multiply_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  ecsm_pkg::coord_t prime_reg;
  ecsm_pkg::coord_t curve_a_reg;
  ecsm_pkg::result_t pending_products[$];
  int errors = 0;
  int burst_left = 0;
  int stall_phase = 0;

  // ---------------------------------------------------------------- field math
  function automatic ecsm_pkg::coord_t mod_add(ecsm_pkg::coord_t a, ecsm_pkg::coord_t b,
                                               ecsm_pkg::coord_t m);
    logic [ecsm_pkg::COORD_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[ecsm_pkg::COORD_WIDTH-1:0];
  endfunction

  function automatic ecsm_pkg::coord_t mod_sub(ecsm_pkg::coord_t a, ecsm_pkg::coord_t b,
                                               ecsm_pkg::coord_t m);
    return (a >= b) ? a - b : a - b + m;
  endfunction

  function automatic ecsm_pkg::coord_t mod_mul(ecsm_pkg::coord_t a, ecsm_pkg::coord_t b,
                                               ecsm_pkg::coord_t m);
    logic [2*ecsm_pkg::COORD_WIDTH-1:0] p;
    p = {{ecsm_pkg::COORD_WIDTH{1'b0}}, a} * {{ecsm_pkg::COORD_WIDTH{1'b0}}, b};
    p = p % {{ecsm_pkg::COORD_WIDTH{1'b0}}, m};
    return p[ecsm_pkg::COORD_WIDTH-1:0];
  endfunction

  // Bezout coefficient of v; for a composite modulus this is not a true inverse.
  function automatic ecsm_pkg::coord_t mod_inv(ecsm_pkg::coord_t v, ecsm_pkg::coord_t m);
    ecsm_pkg::coord_t r0, r1, t0, t1, q, r, tn;
    r0 = m;
    r1 = v;
    t0 = '0;
    t1 = ecsm_pkg::COORD_WIDTH'(1) % m;
    while (r1 != '0) begin
      q = r0 / r1;
      r = r0 % r1;
      tn = mod_sub(t0, mod_mul(q % m, t1, m), m);
      r0 = r1;
      r1 = r;
      t0 = t1;
      t1 = tn;
    end
    return t0;
  endfunction

  function automatic ecsm_pkg::point_t point_sum(ecsm_pkg::point_t p, ecsm_pkg::point_t q,
                                                 ecsm_pkg::coord_t m, ecsm_pkg::coord_t a);
    ecsm_pkg::point_t s;
    ecsm_pkg::coord_t lam, x2, num;
    s = '{inf: 1'b1, x: '0, y: '0};
    if (p.inf && q.inf) return s;
    if (q.inf) return p;
    if (p.inf) return q;
    if (p.x != q.x) begin
      lam = mod_mul(mod_sub(q.y, p.y, m), mod_inv(mod_sub(q.x, p.x, m), m), m);
      s.x = mod_sub(mod_sub(mod_mul(lam, lam, m), p.x, m), q.x, m);
      s.y = mod_sub(mod_mul(lam, mod_sub(p.x, s.x, m), m), p.y, m);
      s.inf = 1'b0;
    end else if (p.y == q.y && mod_add(p.y, p.y, m) != '0) begin
      x2 = mod_mul(p.x, p.x, m);
      num = mod_add(mod_add(mod_add(x2, x2, m), x2, m), a, m);
      lam = mod_mul(num, mod_inv(mod_add(p.y, p.y, m), m), m);
      s.x = mod_sub(mod_mul(lam, lam, m), mod_add(p.x, p.x, m), m);
      s.y = mod_sub(mod_mul(lam, mod_sub(p.x, s.x, m), m), p.y, m);
      s.inf = 1'b0;
    end
    return s;
  endfunction

  function automatic ecsm_pkg::result_t point_multiple(ecsm_pkg::coord_t x,
                                                       ecsm_pkg::coord_t y, logic inf,
                                                       ecsm_pkg::scalar_t k);
    ecsm_pkg::point_t dbl[ecsm_pkg::SCALAR_WIDTH];
    ecsm_pkg::point_t acc;
    ecsm_pkg::result_t res;
    ecsm_pkg::coord_t m, a;
    int top;
    m = (prime_reg < ecsm_pkg::MIN_PRIME) ? ecsm_pkg::MIN_PRIME : prime_reg;
    a = curve_a_reg % m;
    res = '{x: '0, y: '0, inf: 1'b1, err: 1'b0};
    top = 0;
    if (k == '0) begin
      res.err = 1'b1;
      return res;
    end
    dbl[0] = '{inf: inf, x: x % m, y: y % m};
    for (int i = ecsm_pkg::SCALAR_WIDTH - 1; i >= 0; i--) begin
      if (k[i]) begin
        top = i;
        break;
      end
    end
    for (int i = 1; i <= top; i++) dbl[i] = point_sum(dbl[i-1], dbl[i-1], m, a);
    acc = dbl[top];
    for (int i = top - 1; i >= 0; i--) begin
      if (k[i]) acc = point_sum(dbl[i], acc, m, a);
    end
    if (!acc.inf) begin
      res.x = acc.x;
      res.y = acc.y;
      res.inf = 1'b0;
    end
    return res;
  endfunction

  // ------------------------------------------------------------------ drivers
  task automatic write_reg(logic [ecsm_pkg::CFG_IDX_W-1:0] idx, ecsm_pkg::coord_t value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == ecsm_pkg::CFG_PRIME_MODULUS) prime_reg = value;
    else if (idx == ecsm_pkg::CFG_CURVE_A) curve_a_reg = value;
  endtask

  // Returns at the accepting edge with valid still high.
  task automatic send_point(ecsm_pkg::coord_t x, ecsm_pkg::coord_t y, logic inf,
                            ecsm_pkg::scalar_t k);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 6);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.point_x <= x;
    in_ch.point_y <= y;
    in_ch.point_is_infinity <= inf;
    in_ch.scalar <= k;
    do @(posedge clk); while (!in_ch.ready);
    pending_products.push_back(point_multiple(x, y, inf, k));
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // The receiver alternates calm stretches with random stalls.
  always @(posedge clk) begin
    stall_phase <= (stall_phase + 1) % 300;
    if (stall_phase < 100) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk) begin
    ecsm_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_products.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        want = pending_products.pop_front();
        if (out_ch.result_x !== want.x) begin
          $error("result_x expected %h actual %h", want.x, out_ch.result_x);
          errors++;
        end
        if (out_ch.result_y !== want.y) begin
          $error("result_y expected %h actual %h", want.y, out_ch.result_y);
          errors++;
        end
        if (out_ch.result_is_infinity !== want.inf) begin
          $error("result_is_infinity expected %b actual %b", want.inf,
                 out_ch.result_is_infinity);
          errors++;
        end
        if (out_ch.zero_scalar_error !== want.err) begin
          $error("zero_scalar_error expected %b actual %b", want.err,
                 out_ch.zero_scalar_error);
          errors++;
        end
      end
    end
  end

  // -------------------------------------------------------------------- tests
  task automatic test_reset_curve;
    send_point(64'd5, 64'd7, 1'b0, 64'd1);
    send_point('1, '1, 1'b0, 64'd3);
    send_point(64'd0, 64'd0, 1'b0, 64'd2);
    send_point(64'd9, 64'd11, 1'b0, 64'd0);
    send_point(64'd9, 64'd11, 1'b1, 64'd6);
    send_point(64'h1234_5678_9abc_def0, 64'h0fed_cba9_8765_4321, 1'b0,
               64'h8000_0000_0000_0001);
    drain();
  endtask

  task automatic test_small_prime;
    write_reg(ecsm_pkg::CFG_PRIME_MODULUS, 64'd97);
    write_reg(ecsm_pkg::CFG_CURVE_A, 64'd2);
    // y = 0 doubles to infinity; adding the negation cancels too.
    send_point(64'd3, 64'd0, 1'b0, 64'd2);
    send_point(64'd3, 64'd6, 1'b0, 64'd5);
    send_point(64'd100, 64'd194, 1'b0, 64'd7);
    send_point(64'd17, 64'd10, 1'b0, '1);
    send_point(64'd17, 64'd10, 1'b1, '1);
    send_point(64'd0, 64'd0, 1'b1, 64'd0);
    drain();
  endtask

  task automatic test_degenerate_modulus;
    write_reg(ecsm_pkg::CFG_PRIME_MODULUS, 64'd0);
    write_reg(ecsm_pkg::CFG_CURVE_A, '1);
    send_point(64'd1, 64'd1, 1'b0, 64'd3);
    drain();
    write_reg(ecsm_pkg::CFG_PRIME_MODULUS, 64'd2);
    send_point(64'd4, 64'd2, 1'b0, 64'd5);
    drain();
    write_reg(ecsm_pkg::CFG_PRIME_MODULUS, 64'd15);
    write_reg(ecsm_pkg::CFG_CURVE_A, 64'd0);
    send_point(64'd2, 64'd7, 1'b0, 64'd13);
    send_point(64'd6, 64'd3, 1'b0, 64'd4);
    drain();
    write_reg(ecsm_pkg::CFG_PRIME_MODULUS, '1);
    send_point(64'hdead_beef_0000_0001, 64'h0000_0001_cafe_f00d, 1'b0, 64'd9);
    drain();
  endtask

  task automatic test_random_items;
    ecsm_pkg::coord_t primes[4] = '{64'hFFFF_FFFF_FFFF_FFC5, 64'd97, 64'd65521, 64'd221};
    ecsm_pkg::scalar_t k;
    for (int p = 0; p < 4; p++) begin
      write_reg(ecsm_pkg::CFG_PRIME_MODULUS, primes[p]);
      write_reg(ecsm_pkg::CFG_CURVE_A, {$urandom, $urandom});
      for (int n = 0; n < 19; n++) begin
        case ($urandom_range(0, 19))
          0: k = '0;
          1: k = {1'b1, 31'($urandom), $urandom};
          default: k = ecsm_pkg::SCALAR_WIDTH'($urandom_range(1, 255));
        endcase
        if (primes[p] < 64'd100000 && $urandom_range(0, 1) == 0) begin
          send_point(ecsm_pkg::COORD_WIDTH'($urandom_range(0, 200)),
                     ecsm_pkg::COORD_WIDTH'($urandom_range(0, 200)),
                     $urandom_range(0, 9) == 0, k);
        end else begin
          send_point({$urandom, $urandom}, {$urandom, $urandom},
                     $urandom_range(0, 9) == 0, k);
        end
      end
      drain();
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_is_infinity = 1'b0;
    in_ch.scalar = '0;
    out_ch.ready = 1'b0;
    prime_reg = ecsm_pkg::PRIME_RESET;
    curve_a_reg = ecsm_pkg::CURVE_A_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_curve();
    test_small_prime();
    test_degenerate_modulus();
    test_random_items();
    if (errors == 0) begin
      $display("ec_scalar_multiply_top test passed");
    end else begin
      $display("ec_scalar_multiply_top test failed");
    end
    $finish;
  end

  initial begin
    #(64'd5_000_000_000);
    $display("ec_scalar_multiply_top test failed");
    $finish;
  end

endmodule

>>> files.f
sv/ecsm_pkg.sv
sv/ecsm_if.sv
sv/ecsm_fmul.sv
sv/ecsm_fdiv.sv
sv/ecsm_core.sv
sv/ec_scalar_multiply_top.sv
sim/ec_scalar_multiply_top_tb.sv
